// ===== src/stepper_profile_sequencer_unit_macros.svh =====
// Assertion macros shared by the stepper profile sequencer RTL.
// Included by the files that carry concurrent checks; depends on nothing else.
`ifndef STEPPER_PROFILE_SEQUENCER_UNIT_MACROS_SVH
`define STEPPER_PROFILE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sps_pkg.sv =====
// Shared constants, types and codes of the stepper profile sequencer.
// Used by sps_core and stepper_profile_sequencer_unit; depends on nothing.
package sps_pkg;

    localparam int MOTOR_COUNT  = 2;
    localparam int TABLE_DEPTH  = 64;
    localparam int COUNT_BITS   = 16;

    localparam int MOT_BITS     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int IDX_BITS     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_BITS    = MOT_BITS + IDX_BITS;
    localparam int TABLE_WORDS  = 2 ** ADDR_BITS;
    localparam int EVT_BITS     = COUNT_BITS + 1;
    localparam int SHOWN_MOTORS = (MOTOR_COUNT < 2) ? MOTOR_COUNT : 2;

    // Stream field layout.
    localparam int IN_TDATA_W   = 48;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 8;
    localparam int F_MOTOR      = 0;
    localparam int F_INDEX_LSB  = 1;
    localparam int F_STEPS_LSB  = 7;
    localparam int F_PERIOD_LSB = 23;
    localparam int F_CW         = 39;
    localparam int F_DOSTEP     = 40;
    localparam int O_PULSE_LSB  = 0;
    localparam int O_CW_LSB     = 2;
    localparam int O_EN_LSB     = 4;
    localparam int O_DONE_LSB   = 6;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_ABORT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_ABORT = 2'd3
    } t_core_op;

    typedef struct packed {
        logic [COUNT_BITS-1:0] steps;
        logic [COUNT_BITS-1:0] period;
        logic                  clockwise;
        logic                  do_step;
    } t_seg;

    typedef struct packed {
        t_core_op              op;
        logic [MOT_BITS-1:0]   motor;
        logic [IDX_BITS-1:0]   index;
        logic                  rd_en;
        logic                  rd_prev;
        logic                  wr_en;
        t_seg                  wdata;
    } t_core_ctl;

    typedef struct packed {
        logic                   pulse;
        logic                   done;
        logic [MOTOR_COUNT-1:0] running;
        logic [MOTOR_COUNT-1:0] direction;
    } t_core_stat;

endpackage

// ===== src/sps_core.sv =====
// Segment table memory and per-motor counters of the stepper sequencer.
// Depends on sps_pkg; driven one motor at a time by the top-level sequencer.
module sps_core
    import sps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_core_ctl  i_ctl,
    output t_core_stat o_stat
);

    // Segment table: one synchronous port, read data registered.
    t_seg                 r_table [TABLE_WORDS];
    t_seg                 r_rd_data;

    logic [IDX_BITS-1:0]   r_index      [MOTOR_COUNT];
    logic [EVT_BITS-1:0]   r_event_cnt  [MOTOR_COUNT];
    logic [COUNT_BITS-1:0] r_event_lim  [MOTOR_COUNT];
    logic [COUNT_BITS-1:0] r_period_cnt [MOTOR_COUNT];
    logic [COUNT_BITS-1:0] r_period_rld [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] r_stepping;
    logic [MOTOR_COUNT-1:0] r_direction;
    logic [MOTOR_COUNT-1:0] r_running;

    logic [IDX_BITS-1:0]   cur_index;
    logic [IDX_BITS-1:0]   prev_index;
    logic [ADDR_BITS-1:0]  addr;
    logic                  period_end;
    logic                  segment_end;
    logic                  last_segment;
    logic                  event_hit;

    assign cur_index    = r_index[i_ctl.motor];
    assign prev_index   = IDX_BITS'(cur_index - 1'b1);
    assign addr         = {i_ctl.motor, (i_ctl.rd_prev ? prev_index : i_ctl.index)};
    assign period_end   = (r_period_cnt[i_ctl.motor] == '0);
    assign segment_end  = (r_event_cnt[i_ctl.motor] == {1'b0, r_event_lim[i_ctl.motor]});
    assign last_segment = (cur_index == '0);
    assign event_hit    = (i_ctl.op == OP_TICK) && r_running[i_ctl.motor] && period_end;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_table[addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_table[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_stepping  <= '0;
            r_direction <= '0;
        end else begin
            unique case (i_ctl.op)
                OP_START: begin
                    r_index[i_ctl.motor]      <= i_ctl.index;
                    r_event_cnt[i_ctl.motor]  <= '0;
                    r_event_lim[i_ctl.motor]  <= r_rd_data.steps;
                    r_stepping[i_ctl.motor]   <= r_rd_data.do_step;
                    r_direction[i_ctl.motor]  <= r_rd_data.clockwise;
                    r_period_rld[i_ctl.motor] <= r_rd_data.period;
                    r_period_cnt[i_ctl.motor] <= r_rd_data.period;
                    r_running[i_ctl.motor]    <= 1'b1;
                end
                OP_ABORT: begin
                    r_running[i_ctl.motor]  <= 1'b0;
                    r_stepping[i_ctl.motor] <= 1'b0;
                end
                OP_TICK: begin
                    if (r_running[i_ctl.motor]) begin
                        if (!period_end) begin
                            r_period_cnt[i_ctl.motor] <=
                                COUNT_BITS'(r_period_cnt[i_ctl.motor] - 1'b1);
                        end else if (segment_end && last_segment) begin
                            r_period_cnt[i_ctl.motor] <= r_period_rld[i_ctl.motor];
                            r_event_cnt[i_ctl.motor]  <=
                                EVT_BITS'(r_event_cnt[i_ctl.motor] + 1'b1);
                            r_running[i_ctl.motor]    <= 1'b0;
                            r_stepping[i_ctl.motor]   <= 1'b0;
                        end else if (segment_end) begin
                            // Switch to the next lower entry; its first event is one tick out.
                            r_index[i_ctl.motor]      <= prev_index;
                            r_event_cnt[i_ctl.motor]  <= '0;
                            r_event_lim[i_ctl.motor]  <= r_rd_data.steps;
                            r_stepping[i_ctl.motor]   <= r_rd_data.do_step;
                            r_direction[i_ctl.motor]  <= r_rd_data.clockwise;
                            r_period_rld[i_ctl.motor] <= r_rd_data.period;
                            r_period_cnt[i_ctl.motor] <= '0;
                        end else begin
                            r_period_cnt[i_ctl.motor] <= r_period_rld[i_ctl.motor];
                            r_event_cnt[i_ctl.motor]  <=
                                EVT_BITS'(r_event_cnt[i_ctl.motor] + 1'b1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.pulse     = event_hit && r_stepping[i_ctl.motor]
                              && !(segment_end && last_segment);
    assign o_stat.done      = event_hit && segment_end && last_segment;
    assign o_stat.running   = r_running;
    assign o_stat.direction = r_direction;

endmodule

// ===== src/stepper_profile_sequencer_unit.sv =====
// Top level of the two-motor stepper segment sequencer: request handshake,
// command sequencing and result register. Depends on sps_pkg, sps_core and the macro header.
//
// Use: each request on the slave stream carries a command in tuser (base tick, load
// table entry, start at entry, abort) and its operands in tdata. Every request yields
// exactly one result on the master stream: per-motor step pulse, direction, driver
// enable and finished flags, sampled after the request took effect.
// Flow: a request is taken from the idle state and worked on alone. A base tick does
// a table read and an update per motor, both on the single table port; start does a
// read and an update, abort an update only, a load a table write, and a request naming
// a motor or entry out of range goes straight to the result.
// The result register lets the next request be accepted while a result waits; when the
// receiver stalls, the finished result holds and the following one waits in the
// sequencer, which then takes no new request.
// Reset (synchronous, active low) stops and disables both motors and clears direction
// outputs; table contents are undefined until loaded.
`include "stepper_profile_sequencer_unit_macros.svh"

module stepper_profile_sequencer_unit
    import sps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // motor, entry_index[5:0], entry_steps[15:0], entry_period[15:0],
    // entry_clockwise, entry_do_step, zero padding
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // step_pulse_a, step_pulse_b, clockwise_a, clockwise_b,
    // enable_a, enable_b, finished_a, finished_b
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_APPLY = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    t_cmd                   r_cmd;
    logic [MOT_BITS-1:0]    r_mot;
    logic [IDX_BITS-1:0]    r_index;
    t_seg                   r_entry;
    logic [MOTOR_COUNT-1:0] r_pulse;
    logic [MOTOR_COUNT-1:0] r_done;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    t_core_ctl  core_ctl;
    t_core_stat core_stat;

    logic       s_accept;
    logic       out_free;
    logic       in_range;
    logic       last_motor;
    t_cmd       in_cmd;
    logic [5:0] in_index;
    logic       in_motor;

    assign in_cmd     = t_cmd'(i_s_tuser[1:0]);
    assign in_index   = i_s_tdata[F_INDEX_LSB +: 6];
    assign in_motor   = i_s_tdata[F_MOTOR];
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign last_motor = (32'(r_mot) == MOTOR_COUNT - 1);

    // A request naming a missing motor or entry changes nothing.
    assign in_range = (in_cmd == CMD_TICK)
                      || ((32'(in_motor) < MOTOR_COUNT)
                          && ((in_cmd == CMD_ABORT) || (32'(in_index) < TABLE_DEPTH)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = in_range ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                n_state = (r_cmd == CMD_LOAD) ? S_OUT : S_APPLY;
            end
            S_APPLY: begin
                n_state = ((r_cmd == CMD_TICK) && !last_motor) ? S_READ : S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        core_ctl         = '0;
        core_ctl.op      = OP_NONE;
        core_ctl.motor   = r_mot;
        core_ctl.index   = r_index;
        core_ctl.wdata   = r_entry;
        if (r_state == S_READ) begin
            core_ctl.rd_en   = (r_cmd == CMD_TICK) || (r_cmd == CMD_START);
            core_ctl.rd_prev = (r_cmd == CMD_TICK);
            core_ctl.wr_en   = (r_cmd == CMD_LOAD);
        end
        if (r_state == S_APPLY) begin
            unique case (r_cmd)
                CMD_TICK:  core_ctl.op = OP_TICK;
                CMD_START: core_ctl.op = OP_START;
                CMD_ABORT: core_ctl.op = OP_ABORT;
                default:   core_ctl.op = OP_NONE;
            endcase
        end
    end

    sps_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_stat  (core_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd             <= in_cmd;
            r_mot             <= (in_cmd == CMD_TICK) ? '0 : MOT_BITS'(in_motor);
            r_index           <= IDX_BITS'(in_index);
            r_entry.steps     <= COUNT_BITS'(i_s_tdata[F_STEPS_LSB +: 16]);
            r_entry.period    <= COUNT_BITS'(i_s_tdata[F_PERIOD_LSB +: 16]);
            r_entry.clockwise <= i_s_tdata[F_CW];
            r_entry.do_step   <= i_s_tdata[F_DOSTEP];
            r_pulse           <= '0;
            r_done            <= '0;
        end else if (r_state == S_APPLY) begin
            if (r_cmd == CMD_TICK) begin
                r_pulse[r_mot] <= core_stat.pulse;
                r_done[r_mot]  <= core_stat.done;
                if (!last_motor) begin
                    r_mot <= MOT_BITS'(r_mot + 1'b1);
                end
            end
        end
    end

    always_comb begin
        n_out_data = '0;
        for (int m = 0; m < SHOWN_MOTORS; m++) begin
            n_out_data[O_PULSE_LSB + m] = r_pulse[m];
            n_out_data[O_CW_LSB + m]    = core_stat.direction[m];
            n_out_data[O_EN_LSB + m]    = core_stat.running[m];
            n_out_data[O_DONE_LSB + m]  = r_done[m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `SPS_ASSERT_NEXT(a_one_request_at_a_time, i_clk, i_rst_n, s_accept, !o_s_tready, "request taken while another is in work")
    `SPS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, (r_state == S_OUT) && out_free, o_m_tvalid, "finished request produced no result")
    `SPS_ASSERT_SAME(a_finished_disables, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[O_DONE_LSB], !o_m_tdata[O_EN_LSB], "finished motor still enabled")
    `SPS_ASSERT_SAME(a_no_pulse_on_finish, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[O_DONE_LSB], !o_m_tdata[O_PULSE_LSB], "stopping event emitted a pulse")
    `SPS_ASSERT_SAME(a_core_quiet_when_idle, i_clk, i_rst_n, r_state == S_IDLE, (core_ctl.op == OP_NONE) && !core_ctl.wr_en, "table or counters touched while idle")

endmodule
